/* src/rh_pkg.sv */
// Shared types and constants for the Robin Hood hash table.
// Used by the controller, the datapath, the top level and the checker.
package rh_pkg;

    localparam int CAPACITY     = 1024;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int STEP_W       = IDX_W + 1;
    localparam int KEY_BITS     = 64;
    localparam int PAYLOAD_BITS = 64;
    localparam int LOG2_MIN     = 6;
    localparam int LOG2_MAX     = IDX_W;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [2:0] ST_NEW    = 3'd0;
    localparam logic [2:0] ST_FOUND  = 3'd1;
    localparam logic [2:0] ST_HIT    = 3'd2;
    localparam logic [2:0] ST_MISS   = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;
    localparam logic [2:0] ST_FROZEN = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;

    localparam logic [1:0] REG_LOG2   = 2'd0;
    localparam logic [1:0] REG_MAX    = 2'd1;
    localparam logic [1:0] REG_FROZEN = 2'd2;

    localparam logic [1:0] PH_LOOK  = 2'd0;
    localparam logic [1:0] PH_SCAN  = 2'd1;
    localparam logic [1:0] PH_PLACE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [31:0] hash_value;
        logic [63:0] new_payload;
        logic [9:0]  slot_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] payload_out;
        logic [63:0] key_out;
        logic        slot_occupied;
        logic [9:0]  live_count;
    } t_rsp;

    typedef struct packed {
        logic [3:0] log2_capacity_in_use;
        logic [9:0] max_entries;
        logic       frozen_flag;
    } t_cfg;

    typedef struct packed {
        logic clr;
        logic load_req;
        logic eval;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic eval_done;
        logic out_free;
    } t_sts;

endpackage

/* src/robin_hood_hash_table_top.sv */
// Top level of the Robin Hood hash table: configuration registers and the
// controller and datapath. Depends on rh_pkg, rh_ctrl and rh_datapath.
//
// One request is taken at a time. Each probed slot passes through S_ADDR,
// which reads the slot stores, and S_EVAL, which acts on the registered data.
// A request's result beat is loaded in S_FIN after its last probe, and the
// next request is taken once S_IDLE is reached again; the hand-off waits for
// as long as an earlier result beat is still stalled at the output. An insert
// that places a new entry walks the run twice, once to look for the key and
// once to place it with swaps. A slot read probes one slot. After reset the
// distance store is swept empty one slot a cycle, so no request is taken
// until the sweep is through; configuration writes are accepted throughout.
module robin_hood_hash_table_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  rh_pkg::t_req i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output rh_pkg::t_rsp o_out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rh_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log2_capacity_in_use <= 4'd10;
            r_cfg.max_entries          <= 10'd716;
            r_cfg.frozen_flag          <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LOG2:   r_cfg.log2_capacity_in_use <= pwdata[3:0];
                REG_MAX:    r_cfg.max_entries          <= pwdata[9:0];
                REG_FROZEN: r_cfg.frozen_flag          <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LOG2:   prdata = {28'd0, r_cfg.log2_capacity_in_use};
            REG_MAX:    prdata = {22'd0, r_cfg.max_entries};
            REG_FROZEN: prdata = {31'd0, r_cfg.frozen_flag};
            default:    prdata = '0;
        endcase
    end

    rh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rh_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* src/rh_ctrl.sv */
// Sequencer for the hash table: clearing sweep, request intake, probe loop
// and result hand-off. Depends on rh_pkg.
module rh_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  rh_pkg::t_sts i_sts,
    output rh_pkg::t_cmd o_cmd
);
    import rh_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_ADDR;
                end
            end
            S_ADDR: n_state = S_EVAL;
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.eval_done ? S_FIN : S_ADDR;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

/* src/rh_datapath.sv */
// Slot stores, probe registers and result registers of the hash table.
// Depends on rh_pkg; steered by rh_ctrl.
module rh_datapath (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  rh_pkg::t_req i_req,
    input  rh_pkg::t_cfg i_cfg,
    input  rh_pkg::t_cmd i_cmd,
    output rh_pkg::t_sts o_sts,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output rh_pkg::t_rsp o_out_data
);
    import rh_pkg::*;

    // Distance word: live bit on top, probe distance below.
    logic [IDX_W:0]            m_dist [CAPACITY];
    logic [KEY_BITS-1:0]       m_key  [CAPACITY];
    logic [PAYLOAD_BITS-1:0]   m_pay  [CAPACITY];

    t_req                r_req;
    logic [IDX_W-1:0]    r_idx,   n_idx;
    logic [STEP_W-1:0]   r_step,  n_step;
    logic [1:0]          r_phase, n_phase;
    logic                r_match, n_match;
    logic [STEP_W-1:0]   r_cd,    n_cd;
    logic [KEY_BITS-1:0] r_ck,    n_ck;
    logic [PAYLOAD_BITS-1:0] r_cp, n_cp;
    logic [9:0]          r_count, n_count;
    t_rsp                r_res,   n_res;
    logic [IDX_W:0]      r_rd_dist;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [PAYLOAD_BITS-1:0] r_rd_pay;
    logic                r_out_valid;
    t_rsp                r_out;

    logic [3:0]          l2;
    logic [IDX_W-1:0]    mask;
    logic [STEP_W-1:0]   n_slots;
    logic [IDX_W-1:0]    home, nxt, rd_addr;
    logic                rd_live, key_eq, done;
    logic [STEP_W-1:0]   rd_d;
    logic                wr_dist_en, wr_kp_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W:0]      wr_dist;

    always_comb begin
        l2 = i_cfg.log2_capacity_in_use;
        if (l2 < 4'(LOG2_MIN)) l2 = 4'(LOG2_MIN);
        if (l2 > 4'(LOG2_MAX)) l2 = 4'(LOG2_MAX);
    end
    assign n_slots = STEP_W'(1) << l2;
    assign mask    = IDX_W'(n_slots - STEP_W'(1));

    assign home    = i_req.hash_value[IDX_W-1:0] & mask;
    assign nxt     = (r_idx + IDX_W'(1)) & mask;
    assign rd_addr = (r_req.kind == KIND_READ) ? r_req.slot_index[IDX_W-1:0] : r_idx;
    assign rd_live = r_rd_dist[IDX_W];
    assign rd_d    = {1'b0, r_rd_dist[IDX_W-1:0]};
    assign key_eq  = (r_rd_key == r_req.key);

    always_comb begin
        n_idx      = r_idx;
        n_step     = r_step;
        n_phase    = r_phase;
        n_match    = r_match;
        n_cd       = r_cd;
        n_ck       = r_ck;
        n_cp       = r_cp;
        n_count    = r_count;
        n_res      = r_res;
        done       = 1'b0;
        wr_dist_en = 1'b0;
        wr_kp_en   = 1'b0;
        wr_addr    = r_idx;
        wr_dist    = '0;
        if (i_cmd.clr) begin
            wr_dist_en = 1'b1;
            n_idx      = r_idx + IDX_W'(1);
        end else if (i_cmd.load_req) begin
            n_idx   = home;
            n_step  = '0;
            n_match = 1'b1;
            n_phase = (i_req.kind == KIND_INSERT) ? PH_SCAN : PH_LOOK;
        end else if (i_cmd.eval) begin
            n_res = '0;
            case (r_req.kind)
                KIND_READ: begin
                    done                = 1'b1;
                    n_res.status        = ST_READ;
                    n_res.slot_occupied = rd_live;
                    n_res.payload_out   = rd_live ? r_rd_pay : '0;
                    n_res.key_out       = rd_live ? r_rd_key : '0;
                end
                KIND_LOOKUP: begin
                    if (r_step >= n_slots || !rd_live || rd_d < r_step) begin
                        done         = 1'b1;
                        n_res.status = ST_MISS;
                    end else if (key_eq) begin
                        done              = 1'b1;
                        n_res.status      = ST_HIT;
                        n_res.payload_out = r_rd_pay;
                    end else begin
                        n_idx  = nxt;
                        n_step = r_step + STEP_W'(1);
                    end
                end
                KIND_INSERT: begin
                    if (i_cfg.frozen_flag) begin
                        done         = 1'b1;
                        n_res.status = ST_FROZEN;
                    end else if (r_phase == PH_SCAN) begin
                        if (r_step >= n_slots) begin
                            done         = 1'b1;
                            n_res.status = ST_FULL;
                        end else if (!rd_live) begin
                            if (r_count >= i_cfg.max_entries) begin
                                done         = 1'b1;
                                n_res.status = ST_FULL;
                            end else begin
                                n_phase = PH_PLACE;
                                n_idx   = r_req.hash_value[IDX_W-1:0] & mask;
                                n_cd    = '0;
                                n_ck    = r_req.key;
                                n_cp    = r_req.new_payload;
                            end
                        end else if (r_match && rd_d == r_step && key_eq) begin
                            done              = 1'b1;
                            n_res.status      = ST_FOUND;
                            n_res.payload_out = r_rd_pay;
                        end else begin
                            if (rd_d < r_step) n_match = 1'b0;
                            n_idx  = nxt;
                            n_step = r_step + STEP_W'(1);
                        end
                    end else begin
                        // Placement: the carried entry takes any slot that is
                        // empty or whose resident is closer to home.
                        wr_dist = {1'b1, r_cd[IDX_W-1:0]};
                        if (!rd_live) begin
                            wr_dist_en        = 1'b1;
                            wr_kp_en          = 1'b1;
                            n_count           = r_count + 10'd1;
                            done              = 1'b1;
                            n_res.status      = ST_NEW;
                            n_res.payload_out = r_req.new_payload;
                        end else if (rd_d < r_cd) begin
                            wr_dist_en = 1'b1;
                            wr_kp_en   = 1'b1;
                            n_ck       = r_rd_key;
                            n_cp       = r_rd_pay;
                            n_cd       = rd_d + STEP_W'(1);
                            n_idx      = nxt;
                        end else begin
                            n_cd  = r_cd + STEP_W'(1);
                            n_idx = nxt;
                        end
                    end
                end
                default: begin
                    done         = 1'b1;
                    n_res.status = ST_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_dist_en) m_dist[wr_addr] <= wr_dist;
        if (wr_kp_en) begin
            m_key[wr_addr] <= r_ck;
            m_pay[wr_addr] <= r_cp;
        end
        r_rd_dist <= m_dist[rd_addr];
        r_rd_key  <= m_key[rd_addr];
        r_rd_pay  <= m_pay[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req <= i_req;
        r_step  <= n_step;
        r_phase <= n_phase;
        r_match <= n_match;
        r_cd    <= n_cd;
        r_ck    <= n_ck;
        r_cp    <= n_cp;
        r_res   <= n_res;
        if (i_cmd.load_out) begin
            r_out <= {r_res.status, r_res.payload_out, r_res.key_out,
                      r_res.slot_occupied, r_count};
        end
    end

    assign o_sts.clr_done  = (r_idx == {IDX_W{1'b1}});
    assign o_sts.eval_done = done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

/* src/rh_checker.sv */
// Port-level checks on the hash table's result channel.
// Depends on rh_pkg; bound to robin_hood_hash_table_top below.
module rh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input rh_pkg::t_rsp o_out_data
);
    import rh_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status != 3'd7)
        else $error("undefined status code");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_READ && !o_out_data.slot_occupied
        |-> o_out_data.payload_out == '0 && o_out_data.key_out == '0)
        else $error("empty slot read returned data");

    a_key_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_READ
        |-> o_out_data.key_out == '0 && !o_out_data.slot_occupied)
        else $error("key or occupancy shown outside a slot read");

endmodule

bind robin_hood_hash_table_top rh_checker u_rh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
